[sv/dpf_pkg.sv]
// Package for the debug packet framer: result kinds, the sideband struct
// between parser and emitter, hex digit decode and the reply byte table.
// No dependencies.
package dpf_pkg;

    localparam int unsigned ReplyLen = 5;
    localparam int unsigned IdxW     = $clog2(ReplyLen);

    localparam logic [7:0] ChDollar = 8'h24;   // '$'
    localparam logic [7:0] ChHash   = 8'h23;   // '#'
    localparam logic [7:0] ChPlus   = 8'h2B;   // '+'
    localparam logic [7:0] ChZero   = 8'h30;   // '0'

    // Kind of result run a byte produces
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_ERR   = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;

    typedef logic [1:0] kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } dpf_req_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // Decode one ASCII hex digit (0-9, a-f, A-F)
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t r;
        r.ok    = 1'b0;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r.ok    = 1'b1;
            r.value = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r.ok    = 1'b1;
            r.value = c[3:0] + 4'd9;
        end
        return r;
    endfunction

    // Bytes of the ack plus empty reply: '+', '$', '#', '0', '0'
    function automatic logic [7:0] reply_byte(input logic [IdxW-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = ChPlus;
            3'd1:    b = ChDollar;
            3'd2:    b = ChHash;
            default: b = ChZero;
        endcase
        return b;
    endfunction

endpackage

[sv/dpf_in_if.sv]
// Input channel of the debug packet framer: one received byte per transaction.
// No dependencies.
interface dpf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[sv/dpf_out_if.sv]
// Output channel of the debug packet framer: one result per transaction.
// No dependencies.
interface dpf_out_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] tx_byte;
    logic       last;

    modport source (output valid, output status, output tx_byte, output last, input ready);
    modport sink   (input valid, input status, input tx_byte, input last, output ready);
endinterface

[sv/dpf_parse.sv]
// Input register and framing state machine of the debug packet framer.
// Depends on dpf_pkg and dpf_in_if.
module dpf_parse
(
    input  logic              clk,
    input  logic              rst_n,
    dpf_in_if.sink            in_ch,
    input  logic              run_free,
    output dpf_pkg::dpf_req_t req
);
    import dpf_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_PAYLOAD = 3'd1;
    localparam logic [2:0] PH_DIG1    = 3'd2;
    localparam logic [2:0] PH_DIG2    = 3'd3;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [2:0] phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic [3:0] nib_reg, nib_next;
    kind_t      kind;
    hex_t       dig;
    logic       move;

    assign move         = in_valid_reg && run_free;
    assign in_ch.ready  = !in_valid_reg || run_free;
    assign dig          = hex_decode(in_byte_reg);
    assign req.valid    = move && (kind != KIND_NONE);
    assign req.kind     = kind;

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        nib_next   = nib_reg;
        kind       = KIND_NONE;
        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                if (in_byte_reg == ChHash)
                    phase_next = PH_DIG1;
                else
                    sum_next = sum_reg + in_byte_reg;
            end
            PH_DIG1:
            begin
                if (!dig.ok)
                begin
                    kind       = KIND_ERR;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    nib_next   = dig.value;
                    phase_next = PH_DIG2;
                end
            end
            PH_DIG2:
            begin
                phase_next = PH_IDLE;
                if (!dig.ok)
                    kind = KIND_ERR;
                else if ({nib_reg, dig.value} == sum_reg)
                    kind = KIND_REPLY;
            end
            default:
            begin
                // idle: consume acks and noise, open a packet on '$'
                phase_next = PH_IDLE;
                if (in_byte_reg == ChDollar)
                begin
                    sum_next   = 8'd0;
                    phase_next = PH_PAYLOAD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            sum_reg      <= 8'd0;
            nib_reg      <= 4'd0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                in_valid_reg <= 1'b1;
            else if (move)
                in_valid_reg <= 1'b0;
            if (move)
            begin
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                nib_reg   <= nib_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            in_byte_reg <= in_ch.rx_byte;
    end

endmodule

[sv/dpf_emit.sv]
// Result register of the debug packet framer: plays out an error result or
// the five-byte reply run. Depends on dpf_pkg and dpf_out_if.
module dpf_emit
(
    input  logic              clk,
    input  logic              rst_n,
    input  dpf_pkg::dpf_req_t req,
    output logic              run_free,
    dpf_out_if.source         out_ch
);
    import dpf_pkg::*;

    logic            run_valid_reg;
    kind_t           run_kind_reg;
    logic [IdxW-1:0] run_idx_reg;
    logic            is_err;
    logic            is_last;
    logic            beat;

    assign is_err   = (run_kind_reg == KIND_ERR);
    assign is_last  = is_err || (run_idx_reg == IdxW'(ReplyLen - 1));
    assign beat     = out_ch.valid && out_ch.ready;
    assign run_free = !run_valid_reg || (beat && is_last);

    assign out_ch.valid   = run_valid_reg;
    assign out_ch.status  = is_err;
    assign out_ch.tx_byte = is_err ? 8'd0 : reply_byte(run_idx_reg);
    assign out_ch.last    = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            run_kind_reg  <= KIND_NONE;
            run_idx_reg   <= '0;
        end
        else if (run_free)
        begin
            run_valid_reg <= req.valid;
            run_kind_reg  <= req.kind;
            run_idx_reg   <= '0;
        end
        else if (beat)
        begin
            run_idx_reg <= run_idx_reg + 1'b1;
        end
    end

endmodule

[sv/debug_packet_framer_core.sv]
// Top level of the debug packet framer: input register, framing state
// machine and result register. Depends on dpf_pkg, dpf_in_if, dpf_out_if,
// dpf_parse and dpf_emit.
//
// Receive-side framing of a remote-debug serial link. Feed received bytes
// one per transaction on in_ch. Outside a packet, '+', '-' and noise are
// dropped; '$' opens a packet, payload bytes up to '#' are summed modulo 256
// and the two following hex digits are checked against that sum. A good
// checksum yields the run '+','$','#','0','0' on out_ch (last set on the
// final '0'); a mismatch yields nothing; a non-hex digit yields one result
// with status 1, tx_byte 0 and last 1, and the framer returns to idle.
// Rate: while the result register is free, bytes that produce no result flow
// at one per clock. A byte that produces a result holds the framer until its
// run drains through the single result register, at one result per clock
// while out_ch is ready. One byte is buffered in the input register while a
// run drains.
module debug_packet_framer_core
(
    input  logic       clk,
    input  logic       rst_n,
    dpf_in_if.sink     in_ch,
    dpf_out_if.source  out_ch
);
    import dpf_pkg::*;

    dpf_req_t req;
    logic     run_free;

    // Parse bytes and advance the framing state when the result stage frees
    dpf_parse u_parse
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .run_free (run_free),
        .req      (req)
    );

    // Hold and play out the result run of the last byte that produced one
    dpf_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .run_free (run_free),
        .out_ch   (out_ch)
    );

endmodule
